// File: design/bwd_pkg.sv
package bwd_pkg;

  localparam int CHAR_W       = 8;
  localparam int SYM_W        = 5;
  localparam int PM_W         = 30;
  localparam int CNT_W        = 6;
  localparam int WIN_USED     = 32;
  localparam int WIN_DEPTH    = 38;
  localparam int PROG_W       = WIN_USED * SYM_W;
  localparam logic [CNT_W-1:0] COUNT_MAX  = 6'd63;
  localparam logic [CNT_W-1:0] DATA_COUNT = 6'd39;

  localparam logic [CHAR_W-1:0] CHAR_SEP = 8'h31;  // '1'
  localparam logic [CHAR_W-1:0] CHAR_B   = 8'h62;  // 'b'
  localparam logic [CHAR_W-1:0] CHAR_C   = 8'h63;  // 'c'

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_MIXED     = 3'd1,
    ERR_SEPARATOR = 3'd2,
    ERR_PREFIX    = 3'd3,
    ERR_BAD_CHAR  = 3'd4,
    ERR_CHECKSUM  = 3'd5,
    ERR_LENGTH    = 3'd6
  } err_code_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_text;
  } item_t;

  typedef struct packed {
    logic        valid_res;
    err_code_t   error_code;
    logic [63:0] program_high;
    logic [63:0] program_middle;
    logic [31:0] program_low;
  } result_t;

  typedef struct packed {
    logic hit;
    logic [SYM_W-1:0] value;
  } sym_t;

  localparam logic [PM_W-1:0] GEN_POLY [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  localparam logic [CHAR_W-1:0] SYMBOLS [32] = '{
    "q", "p", "z", "r", "y", "9", "x", "8", "g", "f", "2", "t", "v", "d", "w", "0",
    "s", "3", "j", "n", "5", "4", "k", "h", "c", "e", "6", "m", "u", "a", "7", "l"
  };

  // One BCH polymod step.
  function automatic logic [PM_W-1:0] pm_step(logic [PM_W-1:0] chk,
                                               logic [SYM_W-1:0] v);
    logic [4:0]      hi5;
    logic [PM_W-1:0] r;
    hi5 = chk[PM_W-1:PM_W-5];
    r   = {chk[PM_W-6:0], v};
    for (int j = 0; j < 5; j++) begin
      if (hi5[j]) r = r ^ GEN_POLY[j];
    end
    return r;
  endfunction

  // Polymod after the expanded "bc" prefix.
  function automatic logic [PM_W-1:0] prefix_preload();
    logic [PM_W-1:0] chk;
    chk = 30'd1;
    chk = pm_step(chk, {2'b00, CHAR_B[7:5]});
    chk = pm_step(chk, {2'b00, CHAR_C[7:5]});
    chk = pm_step(chk, 5'd0);
    chk = pm_step(chk, CHAR_B[4:0]);
    chk = pm_step(chk, CHAR_C[4:0]);
    return chk;
  endfunction

  localparam logic [PM_W-1:0] PRELOAD = prefix_preload();

  function automatic sym_t sym_lookup(logic [CHAR_W-1:0] c);
    sym_t s;
    s = '0;
    for (int i = 0; i < 32; i++) begin
      if (SYMBOLS[i] == c) begin
        s.hit   = 1'b1;
        s.value = SYM_W'(i);
      end
    end
    return s;
  endfunction

endpackage

// File: design/bwd_in_reg.sv
module bwd_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  bwd_pkg::item_t s_item,
  input  logic          take,
  output logic          held_valid,
  output bwd_pkg::item_t held_item
);
  import bwd_pkg::*;

  logic held_valid_next;

  assign s_tready = !held_valid || take;

  always_comb begin
    held_valid_next = held_valid;
    if (s_tvalid && s_tready) held_valid_next = 1'b1;
    else if (take)            held_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) held_item <= s_item;
  end

endmodule

// File: design/bwd_core.sv
module bwd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             held_valid,
  input  bwd_pkg::item_t   held_item,
  input  logic             out_free,
  output logic             take,
  output logic             res_load,
  output bwd_pkg::result_t res
);
  import bwd_pkg::*;

  logic [PM_W-1:0]  polymod_value, polymod_value_next;
  logic [CNT_W-1:0] char_count, char_count_next;
  logic [CNT_W-1:0] separator_index, separator_index_next;
  logic separator_seen, separator_seen_next;
  logic saw_lower, saw_lower_next;
  logic saw_upper, saw_upper_next;
  logic prefix_matches, prefix_matches_next;
  logic bad_data_char, bad_data_char_next;
  logic version_is_zero, version_is_zero_next;
  logic [SYM_W-1:0] data_window [WIN_USED];

  logic [CHAR_W-1:0] c;
  logic              is_lower, is_upper;
  sym_t              sym;
  logic [CNT_W:0]    pos, pos_m1;
  logic              win_we;
  logic [4:0]        win_idx;
  logic [PROG_W-1:0] prog;
  logic [CNT_W-1:0]  data_len;
  err_code_t         code;

  assign take     = held_valid && (!held_item.end_of_text || out_free);
  assign res_load = take && held_item.end_of_text;

  always_comb begin
    is_lower = held_item.char_code >= "a" && held_item.char_code <= "z";
    is_upper = held_item.char_code >= "A" && held_item.char_code <= "Z";
    c   = is_upper ? held_item.char_code + 8'd32 : held_item.char_code;
    sym = sym_lookup(c);
    // position of this char within the data part; negative means none
    pos    = {1'b0, char_count} - {1'b0, separator_index} - 7'd1;
    pos_m1 = pos - 7'd1;

    polymod_value_next   = polymod_value;
    char_count_next      = char_count;
    separator_index_next = separator_index;
    separator_seen_next  = separator_seen;
    saw_lower_next       = saw_lower;
    saw_upper_next       = saw_upper;
    prefix_matches_next  = prefix_matches;
    bad_data_char_next   = bad_data_char;
    version_is_zero_next = version_is_zero;
    win_we  = 1'b0;
    win_idx = pos_m1[4:0];

    if (take) begin
      if (is_lower) saw_lower_next = 1'b1;
      if (is_upper) saw_upper_next = 1'b1;
      if (c == CHAR_SEP) begin
        // any later separator wins, which ruins the prefix
        prefix_matches_next  = !separator_seen && prefix_matches && char_count == 6'd2;
        separator_seen_next  = 1'b1;
        separator_index_next = char_count;
        polymod_value_next   = PRELOAD;
        bad_data_char_next   = 1'b0;
        version_is_zero_next = 1'b0;
      end else if (!separator_seen) begin
        if (char_count == 6'd0)      prefix_matches_next = (c == CHAR_B);
        else if (char_count == 6'd1) prefix_matches_next = prefix_matches && (c == CHAR_C);
        else                         prefix_matches_next = 1'b0;
      end else if (!sym.hit) begin
        bad_data_char_next = 1'b1;
      end else begin
        polymod_value_next = pm_step(polymod_value, sym.value);
        if (pos == 7'd0) version_is_zero_next = (sym.value == 5'd0);
        else if (!pos[CNT_W] && pos_m1 < 7'(WIN_USED)) win_we = 1'b1;
      end
      if (char_count != COUNT_MAX) char_count_next = char_count + 6'd1;
    end

    // result from the state after this character
    data_len = char_count_next - separator_index_next - 6'd1;
    if (saw_lower_next && saw_upper_next)
      code = ERR_MIXED;
    else if (!separator_seen_next || separator_index_next == 6'd0 ||
             {1'b0, separator_index_next} + 7'd7 > {1'b0, char_count_next})
      code = ERR_SEPARATOR;
    else if (!prefix_matches_next)
      code = ERR_PREFIX;
    else if (bad_data_char_next)
      code = ERR_BAD_CHAR;
    else if (polymod_value_next != 30'd1)
      code = ERR_CHECKSUM;
    else if (data_len != DATA_COUNT || !version_is_zero_next)
      code = ERR_LENGTH;
    else
      code = ERR_OK;

    for (int i = 0; i < WIN_USED; i++) begin
      prog[PROG_W-1-i*SYM_W -: SYM_W] = data_window[i];
    end
    if (code != ERR_OK) prog = '0;

    res.valid_res      = (code == ERR_OK);
    res.error_code     = code;
    res.program_high   = prog[159:96];
    res.program_middle = prog[95:32];
    res.program_low    = prog[31:0];

    // end of text: back to the idle state for the next address
    if (res_load) begin
      polymod_value_next   = 30'd1;
      char_count_next      = '0;
      separator_index_next = '0;
      separator_seen_next  = 1'b0;
      saw_lower_next       = 1'b0;
      saw_upper_next       = 1'b0;
      prefix_matches_next  = 1'b0;
      bad_data_char_next   = 1'b0;
      version_is_zero_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      polymod_value   <= 30'd1;
      char_count      <= '0;
      separator_index <= '0;
      separator_seen  <= 1'b0;
      saw_lower       <= 1'b0;
      saw_upper       <= 1'b0;
      prefix_matches  <= 1'b0;
      bad_data_char   <= 1'b0;
      version_is_zero <= 1'b0;
    end else begin
      polymod_value   <= polymod_value_next;
      char_count      <= char_count_next;
      separator_index <= separator_index_next;
      separator_seen  <= separator_seen_next;
      saw_lower       <= saw_lower_next;
      saw_upper       <= saw_upper_next;
      prefix_matches  <= prefix_matches_next;
      bad_data_char   <= bad_data_char_next;
      version_is_zero <= version_is_zero_next;
    end
  end

  always_ff @(posedge clk) begin
    if (win_we) data_window[win_idx] <= sym.value;
  end

`ifndef SYNTHESIS
  // polymod only moves once a separator has been taken
  a_pm_idle: assert property (@(posedge clk) disable iff (rst)
    !separator_seen |-> polymod_value == 30'd1)
    else $error("polymod changed before separator");

  // an empty text carries no flags
  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    char_count == 6'd0 |-> !separator_seen && !saw_lower && !saw_upper)
    else $error("flags set with zero count");

  // separator position never runs ahead of the byte count
  a_sep_order: assert property (@(posedge clk) disable iff (rst)
    separator_seen |-> separator_index <= char_count)
    else $error("separator index past byte count");
`endif

endmodule

// File: design/bwd_out_reg.sv
module bwd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_load,
  input  bwd_pkg::result_t res,
  output logic             out_free,
  output logic             m_tvalid,
  input  logic             m_tready,
  output bwd_pkg::result_t m_res
);
  import bwd_pkg::*;

  logic m_tvalid_next;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (res_load)      m_tvalid_next = 1'b1;
    else if (m_tready) m_tvalid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) m_res <= res;
  end

`ifndef SYNTHESIS
  a_valid_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_res.valid_res == (m_res.error_code == ERR_OK))
    else $error("valid flag disagrees with error code");

  a_zero_prog: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_res.valid_res |->
      m_res.program_high == '0 && m_res.program_middle == '0 && m_res.program_low == '0)
    else $error("program not zero on failed decode");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_res))
    else $error("result changed while stalled");
`endif

endmodule

// File: design/bech32_witness_address_decoder_top.sv
// Channel  | Dir | Signals                    | Contents
// ---------+-----+----------------------------+-----------------------------------------
// s_       | in  | tvalid tready tdata tlast  | one address byte; tlast = end_of_text
// m_       | out | tvalid tready tdata tuser  | one decode result per address text
//
// One byte per cycle while no untaken result stalls a last byte: each byte is
// registered, then a single polymod step and symbol match update the state.
// m_tvalid rises when a text's result is loaded into the result register.
// rst is synchronous, active high; it clears handshake and decode state.
// A last byte waits in the input register while the output register still
// holds an untaken result; only then does s_tready drop for the next byte.
module bech32_witness_address_decoder_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] char_code
  input  logic         s_tlast,   // end_of_text
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,   // [63:0] program_high, [127:64] program_middle,
                                  // [159:128] program_low
  output logic [3:0]   m_tuser    // [0] valid_res, [3:1] error_code
);
  import bwd_pkg::*;

  item_t   s_item;
  item_t   held_item;
  logic    held_valid;
  logic    take;
  logic    out_free;
  logic    res_load;
  result_t res;
  result_t m_res;

  assign s_item.char_code   = s_tdata;
  assign s_item.end_of_text = s_tlast;

  // input request register
  bwd_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_item     (s_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // per-character state update and end-of-text checks
  bwd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held_item  (held_item),
    .out_free   (out_free),
    .take       (take),
    .res_load   (res_load),
    .res        (res)
  );

  // result register
  bwd_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .res_load (res_load),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (m_res)
  );

  assign m_tdata = {m_res.program_low, m_res.program_middle, m_res.program_high};
  assign m_tuser = {m_res.error_code, m_res.valid_res};

endmodule
